>>> hdl/ccq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coalescing command queue package
// Shared widths, entry and key types, result codes and compare result struct.
// ----------------------------------------------------------------------------
package ccq_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Opcodes of an input item.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DRAIN   = 1'b1;

    // Result types.
    localparam logic [1:0] RT_ENQ_STATUS = 2'd0;
    localparam logic [1:0] RT_ENTRY      = 2'd1;
    localparam logic [1:0] RT_EMPTY      = 2'd2;

    // Enqueue status codes.
    localparam logic [1:0] ST_APPENDED = 2'd0;
    localparam logic [1:0] ST_REPLACED = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;

    typedef struct packed {
        logic [15:0] session;
        logic [31:0] sequence_num;
        logic [7:0]  kind;
        logic [47:0] tick;
        logic [47:0] recv_time;
        logic [47:0] client_time;
        logic [63:0] payload;
    } entry_t;

    // Sort key, most significant field first.
    typedef struct packed {
        logic [47:0] tick;
        logic [15:0] session;
        logic [31:0] sequence_num;
    } key_t;

    typedef struct packed {
        logic key_less;
        logic move_hit;
    } cmp_res_t;

endpackage

>>> hdl/ccq_cmp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coalescing command queue compare unit
// Compares one stored entry against the running minimum key and against the
// pending move command. Shared by the enqueue scan and the drain selection.
// ----------------------------------------------------------------------------
module ccq_cmp_unit
(
    input  ccq_pkg::entry_t   ent,
    input  ccq_pkg::key_t     ref_key,
    input  logic [15:0]       cmd_session,
    input  logic [7:0]        move_code,
    output ccq_pkg::cmp_res_t res
);

    ccq_pkg::key_t ent_key;

    assign ent_key.tick         = ent.tick;
    assign ent_key.session      = ent.session;
    assign ent_key.sequence_num = ent.sequence_num;

    // The key fields are packed most significant first, so one unsigned
    // compare gives the lexicographic order.
    assign res.key_less = (ent_key < ref_key);
    assign res.move_hit = (ent.session == cmd_session) && (ent.kind == move_code);

endmodule

>>> hdl/coalescing_command_queue_sorted_drain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coalescing command queue with sorted drain
// Table of pending commands with in-place move coalescing and a drain that
// emits every entry in order of tick, session and sequence number.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on in_valid/in_ready with opcode and command fields.
//   Results leave on out_valid/out_ready, one output register deep; last marks
//   the final result of each input item. The user must write the move
//   code register via cfg_wr_en/cfg_wr_data only while idle (not enforced).
//   A move enqueue into a non-empty table scans its N entries one per cycle
//   through a single read port and shared comparator, and stops at the first
//   matching entry; its status then waits for the output register. Any other
//   enqueue, and a drain of an empty table, goes straight to the state that
//   writes its one result into the output register.
//   A drain runs one selection pass over all N entries for every result, so
//   a full drain runs N passes; the single memory read port makes each result
//   wait for a full pass, and each emit also waits for the output register.
//   in_ready is high only while no item is in progress. If the receiver
//   stalls, the block holds its next result until the output register frees.
//   Reset empties the table and clears the move code to zero; the entry
//   memory itself is not cleared.
// ----------------------------------------------------------------------------
module coalescing_command_queue_sorted_drain
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [15:0] session_id,
    input  logic [31:0] sequence_num,
    input  logic [7:0]  command_kind,
    input  logic [47:0] accepted_tick,
    input  logic [47:0] recv_time_ms,
    input  logic [47:0] client_time_ms,
    input  logic [63:0] payload,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_type,
    output logic [1:0]  enqueue_status,
    output logic [15:0] out_session,
    output logic [31:0] out_sequence,
    output logic [7:0]  out_kind,
    output logic [47:0] out_tick,
    output logic [47:0] out_recv_time,
    output logic [47:0] out_client_time,
    output logic [63:0] out_payload,
    output logic        last
);

    localparam int IDX_W = ccq_pkg::IDX_W;
    localparam int CNT_W = ccq_pkg::CNT_W;
    localparam int DEPTH = ccq_pkg::TABLE_DEPTH;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_E_SCAN  = 3'd1;
    localparam logic [2:0] S_E_FIN   = 3'd2;
    localparam logic [2:0] S_D_SCAN  = 3'd3;
    localparam logic [2:0] S_D_FETCH = 3'd4;
    localparam logic [2:0] S_D_EMIT  = 3'd5;
    localparam logic [2:0] S_EMPTY   = 3'd6;

    // Entry store.
    ccq_pkg::entry_t mem [DEPTH];
    ccq_pkg::entry_t rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    // Control state.
    logic [2:0]       state_reg, state_next;
    logic [7:0]       move_code_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] sc_addr_reg, sc_addr_next;
    logic [CNT_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             hit_vld_reg, hit_vld_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             best_vld_reg, best_vld_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    ccq_pkg::key_t    best_key_reg, best_key_next;
    logic [DEPTH-1:0] done_reg, done_next;
    ccq_pkg::entry_t  cmd_reg, cmd_next;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       rtype_reg, rtype_next;
    logic [1:0]       status_reg, status_next;
    ccq_pkg::entry_t  oent_reg, oent_next;
    logic             last_reg, last_next;

    logic              issue;
    logic              scan_end;
    logic              out_free;
    logic              last_emit;
    ccq_pkg::cmp_res_t cmp;

    ccq_cmp_unit u_cmp
    (
        .ent         (rd_data_reg),
        .ref_key     (best_key_reg),
        .cmd_session (cmd_reg.session),
        .move_code   (move_code_reg),
        .res         (cmp)
    );

    assign issue    = ((state_reg == S_E_SCAN) || (state_reg == S_D_SCAN))
                      && (sc_addr_reg < cnt_reg);
    assign rd_addr  = issue ? sc_addr_reg[IDX_W-1:0] : best_idx_reg;
    assign scan_end = (sc_addr_reg >= cnt_reg) && !rd_vld_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign last_emit = (CNT_W'(emit_cnt_reg + 1'b1) == cnt_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sc_addr_next   = sc_addr_reg;
        emit_cnt_next  = emit_cnt_reg;
        hit_vld_next   = hit_vld_reg;
        hit_idx_next   = hit_idx_reg;
        best_vld_next  = best_vld_reg;
        best_idx_next  = best_idx_reg;
        best_key_next  = best_key_reg;
        done_next      = done_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rtype_next     = rtype_reg;
        status_next    = status_reg;
        oent_next      = oent_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_addr        = hit_idx_reg;

        if (issue)
        begin
            sc_addr_next = sc_addr_reg + CNT_W'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next.session      = session_id;
                    cmd_next.sequence_num = sequence_num;
                    cmd_next.kind         = command_kind;
                    cmd_next.tick         = accepted_tick;
                    cmd_next.recv_time    = recv_time_ms;
                    cmd_next.client_time  = client_time_ms;
                    cmd_next.payload      = payload;
                    hit_vld_next  = 1'b0;
                    sc_addr_next  = '0;
                    best_vld_next = 1'b0;
                    emit_cnt_next = '0;
                    done_next     = '0;
                    if (opcode == ccq_pkg::OP_DRAIN)
                    begin
                        state_next = (cnt_reg == '0) ? S_EMPTY : S_D_SCAN;
                    end
                    else if ((command_kind == move_code_reg) && (cnt_reg != '0))
                    begin
                        state_next = S_E_SCAN;
                    end
                    else
                    begin
                        state_next = S_E_FIN;
                    end
                end
            end

            S_E_SCAN:
            begin
                if (rd_vld_reg && cmp.move_hit)
                begin
                    hit_vld_next = 1'b1;
                    hit_idx_next = rd_idx_reg;
                    state_next   = S_E_FIN;
                end
                else if (scan_end)
                begin
                    state_next = S_E_FIN;
                end
            end

            S_E_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    rtype_next     = ccq_pkg::RT_ENQ_STATUS;
                    oent_next      = '0;
                    last_next      = 1'b1;
                    if (hit_vld_reg)
                    begin
                        wr_en       = 1'b1;
                        status_next = ccq_pkg::ST_REPLACED;
                    end
                    else if (cnt_reg < CNT_W'(DEPTH))
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = cnt_reg[IDX_W-1:0];
                        cnt_next    = cnt_reg + CNT_W'(1);
                        status_next = ccq_pkg::ST_APPENDED;
                    end
                    else
                    begin
                        status_next = ccq_pkg::ST_DROPPED;
                    end
                    state_next = S_IDLE;
                end
            end

            S_D_SCAN:
            begin
                // Strict less keeps the lowest index among equal keys.
                if (rd_vld_reg && !done_reg[rd_idx_reg] && (!best_vld_reg || cmp.key_less))
                begin
                    best_vld_next              = 1'b1;
                    best_idx_next              = rd_idx_reg;
                    best_key_next.tick         = rd_data_reg.tick;
                    best_key_next.session      = rd_data_reg.session;
                    best_key_next.sequence_num = rd_data_reg.sequence_num;
                end
                if (scan_end)
                begin
                    state_next = S_D_FETCH;
                end
            end

            S_D_FETCH:
            begin
                state_next = S_D_EMIT;
            end

            S_D_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    rtype_next              = ccq_pkg::RT_ENTRY;
                    status_next             = ccq_pkg::ST_APPENDED;
                    oent_next               = rd_data_reg;
                    last_next               = last_emit;
                    done_next[best_idx_reg] = 1'b1;
                    emit_cnt_next           = CNT_W'(emit_cnt_reg + 1'b1);
                    if (last_emit)
                    begin
                        cnt_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        sc_addr_next  = '0;
                        best_vld_next = 1'b0;
                        state_next    = S_D_SCAN;
                    end
                end
            end

            S_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    rtype_next     = ccq_pkg::RT_EMPTY;
                    status_next    = ccq_pkg::ST_APPENDED;
                    oent_next      = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            move_code_reg <= '0;
            cnt_reg       <= '0;
            sc_addr_reg   <= '0;
            emit_cnt_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            hit_vld_reg   <= 1'b0;
            best_vld_reg  <= 1'b0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wr_en)
            begin
                move_code_reg <= cfg_wr_data;
            end
            cnt_reg       <= cnt_next;
            sc_addr_reg   <= sc_addr_next;
            emit_cnt_reg  <= emit_cnt_next;
            rd_vld_reg    <= issue;
            hit_vld_reg   <= hit_vld_next;
            best_vld_reg  <= best_vld_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= sc_addr_reg[IDX_W-1:0];
        hit_idx_reg  <= hit_idx_next;
        best_idx_reg <= best_idx_next;
        best_key_reg <= best_key_next;
        cmd_reg      <= cmd_next;
        rtype_reg    <= rtype_next;
        status_reg   <= status_next;
        oent_reg     <= oent_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign result_type     = rtype_reg;
    assign enqueue_status  = status_reg;
    assign out_session     = oent_reg.session;
    assign out_sequence    = oent_reg.sequence_num;
    assign out_kind        = oent_reg.kind;
    assign out_tick        = oent_reg.tick;
    assign out_recv_time   = oent_reg.recv_time;
    assign out_client_time = oent_reg.client_time;
    assign out_payload     = oent_reg.payload;
    assign last            = last_reg;

    // The fill count never passes the table depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    // The final drained entry empties the table.
    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_D_EMIT) && out_free && last_emit |=> cnt_reg == '0)
        else $error("table not emptied after final drained item");

    // Outside a drain the count only ever grows by one.
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_D_EMIT) |=> (cnt_reg == $past(cnt_reg))
            || (cnt_reg == CNT_W'($past(cnt_reg) + 1'b1)))
        else $error("entry count changed by more than one append");

    // A drain selection never picks an entry that was already emitted.
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_D_EMIT) |-> !done_reg[best_idx_reg])
        else $error("drained entry selected twice");

endmodule
